// File: rtl/core/rmq_pkg.sv
// rmq_pkg: payload structs, internal vector type and datapath widths
// for the rotation matrix to quaternion pipeline
// no dependencies
package rmq_pkg;

  localparam int unsigned ENT_W      = 16;  // matrix entry and quaternion component
  localparam int unsigned CMP_W      = 32;  // signed branch component
  localparam int unsigned ABS_W      = 31;  // component magnitude
  localparam int unsigned MAG_W      = 18;  // scaled magnitude, always below 2^18
  localparam int unsigned SHF_W      = 4;   // scale shift, at most 13
  localparam int unsigned SQ_W       = 2 * MAG_W;
  localparam int unsigned L2_W       = SQ_W + 2;
  localparam int unsigned RAD_SHIFT  = 24;
  localparam int unsigned RAD_W      = L2_W + RAD_SHIFT;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned NORM_SHIFT = 12;
  localparam int unsigned NUM_W      = 62;  // numerator, below 2^61
  localparam int unsigned QUO_W      = 17;  // quotient bits kept before clamping

  typedef struct packed {
    logic signed [ENT_W-1:0] m00;
    logic signed [ENT_W-1:0] m01;
    logic signed [ENT_W-1:0] m02;
    logic signed [ENT_W-1:0] m10;
    logic signed [ENT_W-1:0] m11;
    logic signed [ENT_W-1:0] m12;
    logic signed [ENT_W-1:0] m20;
    logic signed [ENT_W-1:0] m21;
    logic signed [ENT_W-1:0] m22;
  } rmq_matrix_t;

  typedef struct packed {
    logic signed [ENT_W-1:0] qx;
    logic signed [ENT_W-1:0] qy;
    logic signed [ENT_W-1:0] qz;
    logic signed [ENT_W-1:0] qw;
    logic                    invalid;
  } rmq_quat_t;

  typedef logic [MAG_W-1:0] rmq_mag_t;

  // lane 0..3 = x, y, z, w
  typedef struct packed {
    logic                invalid;
    logic [3:0]          neg;
    rmq_mag_t [3:0]      mag;
  } rmq_vec_t;

endpackage

// File: rtl/core/rmq_front.sv
// rmq_front: branch selection, magnitude scaling and sum of squares
// seven register stages; depends on rmq_pkg
module rmq_front #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  rmq_pkg::rmq_matrix_t       mat,
  output logic                       out_valid,
  output rmq_pkg::rmq_vec_t          vec,
  output logic [rmq_pkg::L2_W-1:0]   l2
);
  import rmq_pkg::*;

  localparam int unsigned STAGES = 7;
  localparam int unsigned LEN_W  = $clog2(ABS_W + 1);
  localparam logic signed [CMP_W-1:0] ONE = {{(CMP_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  function automatic logic signed [CMP_W-1:0] sext(input logic signed [ENT_W-1:0] v);
    return {{(CMP_W-ENT_W){v[ENT_W-1]}}, v};
  endfunction

  logic [STAGES-1:0] vld;

  // stage a: branch components
  logic signed [CMP_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, tr, rad;
  logic signed [CMP_W-1:0] cmp_next [4];
  logic                    bad_next;
  logic signed [CMP_W-1:0] cmp_a [4];
  logic                    bad_a;

  always_comb begin
    e00 = sext(mat.m00); e01 = sext(mat.m01); e02 = sext(mat.m02);
    e10 = sext(mat.m10); e11 = sext(mat.m11); e12 = sext(mat.m12);
    e20 = sext(mat.m20); e21 = sext(mat.m21); e22 = sext(mat.m22);
    tr = e00 + e11 + e22;
    bad_next = 1'b0;
    if (tr > 0) begin
      rad = ONE + tr;
      cmp_next[0] = e21 - e12; cmp_next[1] = e02 - e20;
      cmp_next[2] = e10 - e01; cmp_next[3] = rad;
    end else begin
      if (e00 > e11 && e00 > e22) begin
        rad = ONE + e00 - e11 - e22;
        cmp_next[0] = rad;       cmp_next[1] = e01 + e10;
        cmp_next[2] = e02 + e20; cmp_next[3] = e21 - e12;
      end else if (e11 > e22) begin
        rad = ONE + e11 - e00 - e22;
        cmp_next[0] = e01 + e10; cmp_next[1] = rad;
        cmp_next[2] = e12 + e21; cmp_next[3] = e02 - e20;
      end else begin
        rad = ONE + e22 - e00 - e11;
        cmp_next[0] = e02 + e20; cmp_next[1] = e21 + e12;
        cmp_next[2] = rad;       cmp_next[3] = e10 - e01;
      end
      bad_next = (rad <= 0);
    end
  end

  // stage b: magnitudes
  logic [ABS_W-1:0] abs_b [4];
  logic [3:0]       neg_b;
  logic             bad_b;

  // stage c: scale shift
  logic [ABS_W-1:0] abs_c [4];
  logic [3:0]       neg_c;
  logic             bad_c;
  logic [SHF_W-1:0] shf_c;
  logic [ABS_W-1:0] or_all;
  logic [LEN_W-1:0] len;
  logic [SHF_W-1:0] shf_next;

  always_comb begin
    or_all = abs_b[0] | abs_b[1] | abs_b[2] | abs_b[3];
    len = '0;
    for (int i = 0; i < ABS_W; i++) begin
      if (or_all[i]) len = LEN_W'(i + 1);
    end
    shf_next = (len > LEN_W'(MAG_W)) ? SHF_W'(len - LEN_W'(MAG_W)) : '0;
  end

  // stages d..g
  rmq_vec_t          vec_d, vec_e, vec_f;
  logic [SQ_W-1:0]   sq_e [4];
  logic [SQ_W:0]     pair_f [2];
  logic [L2_W-1:0]   sum_g;

  assign sum_g = L2_W'(pair_f[0]) + L2_W'(pair_f[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        cmp_a[l] <= cmp_next[l];
        neg_b[l] <= cmp_a[l][CMP_W-1];
        abs_b[l] <= cmp_a[l][CMP_W-1] ? ABS_W'(-cmp_a[l]) : ABS_W'(cmp_a[l]);
        abs_c[l] <= abs_b[l];
        vec_d.mag[l] <= MAG_W'(abs_c[l] >> shf_c);
        sq_e[l] <= SQ_W'(vec_d.mag[l]) * SQ_W'(vec_d.mag[l]);
      end
      bad_a <= bad_next;
      bad_b <= bad_a;
      neg_c <= neg_b;
      bad_c <= bad_b;
      shf_c <= shf_next;
      vec_d.neg <= neg_c;
      vec_d.invalid <= bad_c;
      vec_e <= vec_d;
      pair_f[0] <= (SQ_W+1)'(sq_e[0]) + (SQ_W+1)'(sq_e[1]);
      pair_f[1] <= (SQ_W+1)'(sq_e[2]) + (SQ_W+1)'(sq_e[3]);
      vec_f <= vec_e;
      l2 <= sum_g;
      vec.mag <= vec_f.mag;
      vec.neg <= vec_f.neg;
      vec.invalid <= vec_f.invalid | (sum_g == '0);
    end
  end

  assign out_valid = vld[STAGES-1];

endmodule

// File: rtl/core/rmq_sqrt.sv
// rmq_sqrt: pipelined integer square root of l2 * 2^24, one root bit per stage
// depends on rmq_pkg
module rmq_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  rmq_pkg::rmq_vec_t           vec_in,
  input  logic [rmq_pkg::L2_W-1:0]    l2_in,
  output logic                        out_valid,
  output rmq_pkg::rmq_vec_t           vec,
  output logic [rmq_pkg::ROOT_W-1:0]  root
);
  import rmq_pkg::*;

  logic [ROOT_W-1:0] vld;
  logic [RAD_W-1:0]  rem_r    [ROOT_W-1];
  logic [ROOT_W-1:0] root_r   [ROOT_W];
  rmq_vec_t          vec_r    [ROOT_W];
  logic [RAD_W-1:0]  rem_src  [ROOT_W];
  logic [ROOT_W-1:0] root_src [ROOT_W];
  logic [RAD_W-1:0]  rem_next [ROOT_W];
  logic [ROOT_W-1:0] root_next[ROOT_W];

  always_comb begin : step
    logic [RAD_W-1:0] trial;
    int b;
    rem_src[0]  = RAD_W'(l2_in) << RAD_SHIFT;
    root_src[0] = '0;
    for (int i = 1; i < ROOT_W; i++) begin
      rem_src[i]  = rem_r[i-1];
      root_src[i] = root_r[i-1];
    end
    for (int i = 0; i < ROOT_W; i++) begin
      b = ROOT_W - 1 - i;
      // (root + 2^b)^2 - root^2
      trial = (RAD_W'(root_src[i]) << (b + 1)) | (RAD_W'(1) << (2 * b));
      if (rem_src[i] >= trial) begin
        rem_next[i]  = rem_src[i] - trial;
        root_next[i] = root_src[i] | (ROOT_W'(1) << b);
      end else begin
        rem_next[i]  = rem_src[i];
        root_next[i] = root_src[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_W-2:0], in_valid};
    end
    if (en) begin
      vec_r[0] <= vec_in;
      for (int i = 0; i < ROOT_W; i++) begin
        root_r[i] <= root_next[i];
        if (i < ROOT_W - 1) rem_r[i] <= rem_next[i];
        if (i > 0) vec_r[i] <= vec_r[i-1];
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign vec       = vec_r[ROOT_W-1];
  assign root      = root_r[ROOT_W-1];

endmodule

// File: rtl/core/rmq_div.sv
// rmq_div: four-lane pipelined restoring divider, rounding, clamp and sign
// one quotient bit per stage; depends on rmq_pkg
module rmq_div #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  rmq_pkg::rmq_vec_t           vec_in,
  input  logic [rmq_pkg::ROOT_W-1:0]  root_in,
  output logic                        out_valid,
  output rmq_pkg::rmq_quat_t          quat
);
  import rmq_pkg::*;

  localparam int unsigned STEPS   = QUO_W;
  localparam int unsigned ONE_INT = 1 << FRAC_BITS;
  localparam int unsigned LIM_INT = (ONE_INT < 32767) ? ONE_INT : 32767;
  localparam logic [QUO_W-1:0] LIM = QUO_W'(LIM_INT);

  logic [STEPS+1:0]  vld;
  logic [NUM_W-1:0]  rem_r    [STEPS][4];
  logic [QUO_W-1:0]  quo_r    [STEPS+1][4];
  logic [ROOT_W-1:0] dvs_r    [STEPS];
  logic [3:0]        neg_r    [STEPS+1];
  logic              bad_r    [STEPS+1];
  logic [NUM_W-1:0]  rem_next [STEPS][4];
  logic [QUO_W-1:0]  quo_next [STEPS][4];
  logic [QUO_W-1:0]  qm       [4];
  logic [ENT_W-1:0]  qv       [4];

  always_comb begin : step
    logic [NUM_W-1:0] trial;
    int b;
    for (int j = 0; j < STEPS; j++) begin
      b = STEPS - 1 - j;
      trial = NUM_W'(dvs_r[j]) << b;
      for (int l = 0; l < 4; l++) begin
        if (rem_r[j][l] >= trial) begin
          rem_next[j][l] = rem_r[j][l] - trial;
          quo_next[j][l] = quo_r[j][l] | (QUO_W'(1) << b);
        end else begin
          rem_next[j][l] = rem_r[j][l];
          quo_next[j][l] = quo_r[j][l];
        end
      end
    end
  end

  // clamp, then apply sign; invalid forces zero
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      qm[l] = (quo_r[STEPS][l] > LIM) ? LIM : quo_r[STEPS][l];
      if (bad_r[STEPS]) begin
        qv[l] = '0;
      end else if (neg_r[STEPS][l]) begin
        qv[l] = ENT_W'(~qm[l] + 1'b1);
      end else begin
        qv[l] = ENT_W'(qm[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS:0], in_valid};
    end
    if (en) begin
      // numerator with half divisor for round half up
      for (int l = 0; l < 4; l++) begin
        rem_r[0][l] <= (NUM_W'(vec_in.mag[l]) << (FRAC_BITS + NORM_SHIFT))
                       + NUM_W'(root_in >> 1);
        quo_r[0][l] <= '0;
      end
      dvs_r[0] <= root_in;
      neg_r[0] <= vec_in.neg;
      bad_r[0] <= vec_in.invalid;
      for (int j = 0; j < STEPS; j++) begin
        for (int l = 0; l < 4; l++) begin
          quo_r[j+1][l] <= quo_next[j][l];
          if (j < STEPS - 1) rem_r[j+1][l] <= rem_next[j][l];
        end
        if (j < STEPS - 1) dvs_r[j+1] <= dvs_r[j];
        neg_r[j+1] <= neg_r[j];
        bad_r[j+1] <= bad_r[j];
      end
      quat.qx      <= qv[0];
      quat.qy      <= qv[1];
      quat.qz      <= qv[2];
      quat.qw      <= qv[3];
      quat.invalid <= bad_r[STEPS];
    end
  end

  assign out_valid = vld[STEPS+1];

endmodule

// File: rtl/core/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion (Shepperd's method) in signed fixed point.
// One transaction on mat carries the nine entries of a 3x3 matrix; one transaction
// on quat returns x, y, z, w (clamped to one, or to 32767 where one does not fit)
// and an invalid flag, set with all components zero when the chosen diagonal
// radicand is not positive or the vector length is zero. The block is a fixed
// pipeline of 57 register stages: 7 for branch selection, scaling and the sum
// of squares, 31 for the square root (one root bit per stage) and 19 for the
// four-lane divider, rounding and clamp. It takes one matrix every cycle unless
// quat is stalled; a stall on quat freezes the whole pipeline and backs up to mat.
// FRAC_BITS sets the fixed-point format and may range from 8 to 30.
// depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div
module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mat_valid,
  output logic                 mat_stall,
  input  rmq_pkg::rmq_matrix_t mat,
  output logic                 quat_valid,
  input  logic                 quat_stall,
  output rmq_pkg::rmq_quat_t   quat
);
  import rmq_pkg::*;

  // pipeline advances unless a finished transaction is held at the output
  logic en;
  assign en        = ~(quat_valid & quat_stall);
  assign mat_stall = ~en;

  logic              front_valid;
  rmq_vec_t          front_vec;
  logic [L2_W-1:0]   front_l2;
  logic              sqrt_valid;
  rmq_vec_t          sqrt_vec;
  logic [ROOT_W-1:0] sqrt_root;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mat_valid),
    .mat       (mat),
    .out_valid (front_valid),
    .vec       (front_vec),
    .l2        (front_l2)
  );

  // length = sqrt(l2 * 2^24)
  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .vec_in    (front_vec),
    .l2_in     (front_l2),
    .out_valid (sqrt_valid),
    .vec       (sqrt_vec),
    .root      (sqrt_root)
  );

  // component / length, final stage is the output register
  rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sqrt_valid),
    .vec_in    (sqrt_vec),
    .root_in   (sqrt_root),
    .out_valid (quat_valid),
    .quat      (quat)
  );

endmodule
